// File: rtl/mlcd_pkg.sv
// Package for the MESI / true-LRU cache tag directory.
// Holds field widths, command and state codes, the result record and controller types.
// No dependencies.
package mlcd_pkg;

    // Fixed field widths of the stream transactions.
    localparam int ADDR_W    = 32;
    localparam int CMD_W     = 3;
    localparam int WAY_FLD_W = 2;
    localparam int VTAG_W    = 14;
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 24;

    // Command codes.
    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_READ  = 3'd0;
    localparam cmd_t CMD_WRITE = 3'd1;
    localparam cmd_t CMD_INVAL = 3'd2;
    localparam cmd_t CMD_PROBE = 3'd3;
    localparam cmd_t CMD_FLUSH = 3'd4;

    // MESI line state codes.
    typedef logic [1:0] mesi_t;
    localparam mesi_t ST_M = 2'd0;
    localparam mesi_t ST_E = 2'd1;
    localparam mesi_t ST_S = 2'd2;
    localparam mesi_t ST_I = 2'd3;

    // Eviction codes.
    typedef logic [1:0] evict_t;
    localparam evict_t EV_NONE  = 2'd0;
    localparam evict_t EV_CLEAN = 2'd1;
    localparam evict_t EV_DIRTY = 2'd2;

    // One result, packed with the hit flag in the lowest bit.
    typedef struct packed {
        mesi_t                 line_state;
        logic                  invalidate_lower;
        logic [VTAG_W-1:0]     victim_tag;
        evict_t                eviction;
        logic [WAY_FLD_W-1:0]  way;
        logic                  hit;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // Controller states.
    typedef enum logic [3:0] {
        FSM_CLEAR  = 4'b0001,
        FSM_IDLE   = 4'b0010,
        FSM_LOOKUP = 4'b0100,
        FSM_FLUSH  = 4'b1000
    } fsm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic finish;
        logic sweep_clear;
        logic sweep_flush;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
    } dp_stat_t;

endpackage

// File: rtl/mlcd_ctrl.sv
// Controller state machine of the cache tag directory.
// Sequences the clearing pass, lookups and flush sweeps. Depends on mlcd_pkg.
module mlcd_ctrl
    import mlcd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_is_flush,
    input  logic     out_free,
    input  dp_stat_t stat,
    output logic     in_ready,
    output dp_cmd_t  cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        cmd.accept      = 1'b0;
        cmd.finish      = 1'b0;
        cmd.sweep_clear = 1'b0;
        cmd.sweep_flush = 1'b0;
        case (state_reg)
            FSM_CLEAR:
            begin
                cmd.sweep_clear = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = in_is_flush ? FSM_FLUSH : FSM_LOOKUP;
                end
            end
            FSM_FLUSH:
            begin
                cmd.sweep_flush = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = FSM_LOOKUP;
                end
            end
            FSM_LOOKUP:
            begin
                cmd.finish = out_free;
                if (out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/mlcd_dpath.sv
// Datapath of the cache tag directory: tag, state and LRU rank memories, one row per set,
// the lookup and update logic and the sweep counter. Depends on mlcd_pkg.
module mlcd_dpath
    import mlcd_pkg::*;
#(
    parameter int INDEX_BITS  = 14,
    parameter int OFFSET_BITS = 4,
    parameter int WAYS        = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           ctl,
    output dp_stat_t          stat,
    input  cmd_t              in_command,
    input  logic [ADDR_W-1:0] in_address,
    input  logic              in_shared,
    output result_t           result
);

    localparam int TAG_W  = ADDR_W - OFFSET_BITS - INDEX_BITS;
    localparam int SETS   = 1 << INDEX_BITS;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam logic [RANK_W-1:0] RANK_LRU = RANK_W'(WAYS - 1);

    typedef logic [WAYS-1:0][TAG_W-1:0]  tag_row_t;
    typedef logic [WAYS-1:0][1:0]        st_row_t;
    typedef logic [WAYS-1:0][RANK_W-1:0] rk_row_t;

    // Memories, one row per set.
    tag_row_t tag_mem [SETS];
    st_row_t  st_mem  [SETS];
    rk_row_t  rk_mem  [SETS];

    // Captured transaction and registered read data.
    cmd_t                  cmd_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [INDEX_BITS-1:0] set_reg;
    logic                  shared_reg;
    tag_row_t              tag_rd_reg;
    st_row_t               st_rd_reg;
    rk_row_t               rk_rd_reg;
    logic [INDEX_BITS-1:0] sweep_cnt_reg;
    logic [INDEX_BITS-1:0] sweep_cnt_next;

    logic [INDEX_BITS-1:0] in_set;
    logic [TAG_W-1:0]      in_tag;
    logic                  sweep;
    logic [INDEX_BITS-1:0] wr_addr;
    logic                  tag_we;
    logic                  st_we;
    logic                  rk_we;
    tag_row_t              tag_wdata;
    st_row_t               st_wdata;
    rk_row_t               rk_wdata;
    tag_row_t              tag_new;
    st_row_t               st_new;
    rk_row_t               rk_new;
    rk_row_t               rk_reset_row;
    logic                  is_rw;
    logic                  is_inv;
    logic                  found;

    assign in_set = in_address[OFFSET_BITS +: INDEX_BITS];
    assign in_tag = in_address[ADDR_W-1 -: TAG_W];
    assign sweep  = ctl.sweep_clear | ctl.sweep_flush;
    assign is_rw  = (cmd_reg == CMD_READ) || (cmd_reg == CMD_WRITE);
    assign is_inv = (cmd_reg == CMD_INVAL);

    // Capture the transaction when it is accepted.
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg    <= in_command;
            tag_reg    <= in_tag;
            set_reg    <= in_set;
            shared_reg <= in_shared;
        end
    end

    // Sweep counter, shared by the clearing pass and flush.
    assign sweep_cnt_next  = sweep ? sweep_cnt_reg + 1'b1 : sweep_cnt_reg;
    assign stat.sweep_last = &sweep_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else
        begin
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    // Reset value of a rank row: each way ranks at its own number.
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            rk_reset_row[w] = RANK_W'(w);
        end
    end

    // Lookup and update of the set that was read.
    always_comb
    begin
        logic [WAY_W-1:0]  f_idx;
        logic [WAY_W-1:0]  l_idx;
        logic [WAY_W-1:0]  a_idx;
        logic [RANK_W-1:0] pivot;
        mesi_t             old_st;
        mesi_t             upd_st;

        found = 1'b0;
        f_idx = '0;
        l_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (st_rd_reg[w] != ST_I && tag_rd_reg[w] == tag_reg)
            begin
                found = 1'b1;
                f_idx = WAY_W'(w);
            end
            if (rk_rd_reg[w] == RANK_LRU)
            begin
                l_idx = WAY_W'(w);
            end
        end
        a_idx  = (is_rw && !found) ? l_idx : f_idx;
        old_st = st_rd_reg[a_idx];
        pivot  = rk_rd_reg[a_idx];

        // New state of the accessed way.
        if (cmd_reg == CMD_WRITE)
        begin
            upd_st = ST_M;
        end
        else if (found)
        begin
            upd_st = old_st;
        end
        else
        begin
            upd_st = shared_reg ? ST_S : ST_E;
        end

        tag_new        = tag_rd_reg;
        tag_new[a_idx] = tag_reg;
        st_new         = st_rd_reg;
        st_new[a_idx]  = is_inv ? ST_I : upd_st;

        // Rank update: move to front on access, to the back on invalidate.
        for (int w = 0; w < WAYS; w++)
        begin
            rk_new[w] = rk_rd_reg[w];
            if (is_inv)
            begin
                if (WAY_W'(w) == a_idx)
                begin
                    rk_new[w] = RANK_LRU;
                end
                else if (rk_rd_reg[w] > pivot)
                begin
                    rk_new[w] = rk_rd_reg[w] - 1'b1;
                end
            end
            else
            begin
                if (rk_rd_reg[w] < pivot)
                begin
                    rk_new[w] = rk_rd_reg[w] + 1'b1;
                end
                else if (rk_rd_reg[w] == pivot)
                begin
                    rk_new[w] = '0;
                end
            end
        end

        // Result fields.
        result = '0;
        result.line_state = ST_I;
        case (cmd_reg)
            CMD_READ, CMD_WRITE:
            begin
                result.hit        = found;
                result.way        = WAY_FLD_W'(a_idx);
                result.line_state = upd_st;
                result.invalidate_lower = (cmd_reg == CMD_WRITE) && found && (old_st == ST_S);
                if (!found && old_st != ST_I)
                begin
                    result.eviction   = (old_st == ST_M) ? EV_DIRTY : EV_CLEAN;
                    result.victim_tag = VTAG_W'(tag_rd_reg[a_idx]);
                end
            end
            CMD_INVAL:
            begin
                result.hit = found;
                result.way = found ? WAY_FLD_W'(a_idx) : '0;
            end
            CMD_PROBE:
            begin
                result.hit        = found;
                result.way        = found ? WAY_FLD_W'(a_idx) : '0;
                result.line_state = found ? old_st : ST_I;
            end
            default:
            begin
                result.line_state = ST_I;
            end
        endcase
    end

    // Write enables and write data.
    assign tag_we    = ctl.finish && is_rw;
    assign st_we     = sweep || (ctl.finish && (is_rw || (is_inv && found)));
    assign rk_we     = ctl.sweep_clear || (ctl.finish && (is_rw || (is_inv && found)));
    assign wr_addr   = sweep ? sweep_cnt_reg : set_reg;
    assign tag_wdata = tag_new;
    assign st_wdata  = sweep ? {WAYS{ST_I}} : st_new;
    assign rk_wdata  = ctl.sweep_clear ? rk_reset_row : rk_new;

    // Tag memory.
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[wr_addr] <= tag_wdata;
        end
        if (ctl.accept)
        begin
            tag_rd_reg <= tag_mem[in_set];
        end
    end

    // State memory.
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[wr_addr] <= st_wdata;
        end
        if (ctl.accept)
        begin
            st_rd_reg <= st_mem[in_set];
        end
    end

    // Rank memory.
    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_mem[wr_addr] <= rk_wdata;
        end
        if (ctl.accept)
        begin
            rk_rd_reg <= rk_mem[in_set];
        end
    end

endmodule

// File: rtl/mlcd_outbuf.sv
// Output register of the cache tag directory: holds one result until the receiver takes it.
// Depends on mlcd_pkg.
module mlcd_outbuf
    import mlcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  result_t              result,
    input  logic                 m_axis_tready,
    output logic                 m_axis_tvalid,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 free
);

    localparam int PAD_W = M_TDATA_W - RESULT_W;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The register can take a new result when empty or drained this cycle.
    assign free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {PAD_W'(0), data_reg};

endmodule

// File: rtl/mesi_lru_cache_directory_unit.sv
// Top level of the set-associative cache tag directory with MESI states and true LRU.
// Instantiates mlcd_ctrl, mlcd_dpath and mlcd_outbuf. Depends on mlcd_pkg.
//
// Usage: a command transaction enters on the s_axis channel (command in tuser, byte
// address and shared_elsewhere in tdata) and exactly one result leaves on m_axis.
// Read, write, invalidate and probe each read the set row from the tag, state and
// rank memories into registers at the accept edge; the row is then compared, updated
// and written back while the result is loaded into the output register. Reading a set
// and writing it back in sequence means a new command is accepted only after the
// previous one has been written back. Flush sweeps the state memory one set per cycle.
// After reset a clearing pass over all 2^INDEX_BITS sets (16384 at the defaults) marks
// all lines Invalid and sets the LRU ranks; s_axis_tready stays low during that pass.
// The output register lets the block finish a command while the previous result is
// being taken; if the receiver holds m_axis_tready low, the next command waits in the
// compare stage and s_axis_tready stays low until the result register drains.
module mesi_lru_cache_directory_unit
    import mlcd_pkg::*;
#(
    parameter int INDEX_BITS  = 14,
    parameter int OFFSET_BITS = 4,
    parameter int WAYS        = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // address[31:0], shared_elsewhere, zero pad
    input  logic [S_TUSER_W-1:0] s_axis_tuser,   // command
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // hit, way, eviction, victim_tag,
                                                 // invalidate_lower, line_state, zero pad
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    result_t  result;
    logic     out_free;
    logic     in_is_flush;

    assign in_is_flush = (s_axis_tuser == CMD_FLUSH);

    // Controller.
    mlcd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_is_flush (in_is_flush),
        .out_free    (out_free),
        .stat        (dp_stat),
        .in_ready    (s_axis_tready),
        .cmd         (dp_cmd)
    );

    // Directory memories and lookup logic.
    mlcd_dpath #(
        .INDEX_BITS  (INDEX_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .WAYS        (WAYS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (dp_cmd),
        .stat       (dp_stat),
        .in_command (s_axis_tuser),
        .in_address (s_axis_tdata[ADDR_W-1:0]),
        .in_shared  (s_axis_tdata[ADDR_W]),
        .result     (result)
    );

    // Result register.
    mlcd_outbuf u_outbuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (dp_cmd.finish),
        .result        (result),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .free          (out_free)
    );

endmodule

// File: rtl/mlcd_checker.sv
// Port-level checks of the cache tag directory, bound to the top level.
// Depends on mlcd_pkg and mesi_lru_cache_directory_unit.
module mlcd_checker
    import mlcd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One command at a time: no accept in the cycle after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted transaction");

    // Eviction code is never the unused value.
    a_evict_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:3] != 2'd3)
        else $error("illegal eviction code");

    // Victim tag is zero when nothing is evicted.
    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4:3] == EV_NONE |-> m_axis_tdata[18:5] == '0)
        else $error("victim tag without eviction");

    // Lower-level invalidation only comes from a write hit that leaves the line Modified.
    a_inval_lower: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[19] |-> m_axis_tdata[0] && m_axis_tdata[21:20] == ST_M)
        else $error("invalidate_lower without a write hit");

endmodule

bind mesi_lru_cache_directory_unit mlcd_checker u_mlcd_checker (.*);
